// ===== sv/argb_pixel_global_alpha_blend_macros.svh =====
// Assertion macros used by the checker file of the blender.
`ifndef ARGB_PIXEL_GLOBAL_ALPHA_BLEND_MACROS_SVH
`define ARGB_PIXEL_GLOBAL_ALPHA_BLEND_MACROS_SVH

// Immediate-cycle property, checked on every clock edge out of reset.
`define AGAB_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("blender check failed");

// Implication property, checked on every clock edge out of reset.
`define AGAB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blender check failed");

`endif

// ===== sv/agab_pkg.sv =====
`default_nettype none
package agab_pkg;

  // Blend mode codes.
  localparam logic [1:0] MODE_COPY    = 2'd0;
  localparam logic [1:0] MODE_LERP    = 2'd1;
  localparam logic [1:0] MODE_SRCOVER = 2'd2;

  // Register indexes on the write port.
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_BLEND_MODE   = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_GLOBAL_ALPHA = 1'd1;

  localparam int CFG_DATA_W = 8;

  // Reset values of the configuration registers.
  localparam logic [1:0] BLEND_MODE_RESET   = MODE_COPY;
  localparam logic [7:0] GLOBAL_ALPHA_RESET = 8'd255;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic       valid;
    logic [1:0] mode;
  } stage_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/argb_pixel_global_alpha_blend.sv =====
`default_nettype none
// Channel   Ports                               Direction  Handshake
// input     start, busy, src_pixel, dst_pixel   in         start && !busy
// result    done, result_pixel                  out        done, one cycle
// config    wr_en, wr_index, wr_data            in         wr_en
//
// One word enters every cycle; busy is held low.
// Each word passes the input register, the multiply register and the output
// register before its result appears.
// Reset (synchronous, active high) clears the valid bits and loads the
// configuration defaults. The receiver cannot stall, so the pipeline never halts.
module argb_pixel_global_alpha_blend (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [31:0]                    src_pixel,
  input  wire logic [31:0]                    dst_pixel,
  output logic                                done,
  output logic      [31:0]                    result_pixel,
  input  wire logic                           wr_en,
  input  wire logic [agab_pkg::REG_IDX_W-1:0] wr_index,
  input  wire logic [agab_pkg::CFG_DATA_W-1:0] wr_data
);
  import agab_pkg::*;

  logic [1:0]  blend_mode;
  logic [7:0]  global_alpha;
  stage_ctrl_t ctrl1;
  stage_ctrl_t ctrl2;
  stage_ctrl_t ctrl3;
  logic [31:0] src1;
  logic [31:0] dst1;
  logic [8:0]  sc1;
  logic [8:0]  dst_weight;

  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode   <= BLEND_MODE_RESET;
      global_alpha <= GLOBAL_ALPHA_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BLEND_MODE:   blend_mode   <= wr_data[1:0];
        REG_GLOBAL_ALPHA: global_alpha <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  // Valid bits and mode travel with the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1 <= '0;
      ctrl2 <= '0;
      ctrl3 <= '0;
    end else begin
      ctrl1 <= '{valid: start && !busy, mode: blend_mode};
      ctrl2 <= ctrl1;
      ctrl3 <= ctrl2;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    src1 <= src_pixel;
    dst1 <= dst_pixel;
    sc1  <= {1'b0, global_alpha} + 9'd1;
  end

  // Destination scale from the source alpha, ready at the combine stage.
  agab_scale u_scale (
    .clk        (clk),
    .src_alpha  (src1[31:24]),
    .sc         (sc1),
    .dst_weight (dst_weight)
  );

  // Four independent byte lanes.
  for (genvar k = 0; k < 4; k++) begin : g_lane
    agab_lane u_lane (
      .clk         (clk),
      .s_byte      (src1[8*k +: 8]),
      .d_byte      (dst1[8*k +: 8]),
      .sc          (sc1),
      .dst_weight  (dst_weight),
      .mode        (ctrl2.mode),
      .result_byte (result_pixel[8*k +: 8])
    );
  end

  assign done = ctrl3.valid;

endmodule
`default_nettype wire

// ===== sv/agab_scale.sv =====
`default_nettype none
module agab_scale (
  input  wire logic       clk,
  input  wire logic [7:0] src_alpha,
  input  wire logic [8:0] sc,
  output logic      [8:0] dst_weight
);
  logic [16:0] alpha_prod;
  logic [15:0] inv_cov;
  logic [16:0] scale_sum;

  // Source alpha times global scale never exceeds 65280, so 16 bits hold it.
  assign alpha_prod = {9'd0, src_alpha} * {8'd0, sc};
  assign inv_cov    = 16'hFFFF - alpha_prod[15:0];

  // Approximate divide by 255 of the inverse coverage.
  assign scale_sum = {1'b0, inv_cov} + {9'd0, inv_cov[15:8]};

  always_ff @(posedge clk) begin
    dst_weight <= scale_sum[16:8];
  end

endmodule
`default_nettype wire

// ===== sv/agab_lane.sv =====
`default_nettype none
module agab_lane (
  input  wire logic       clk,
  input  wire logic [7:0] s_byte,
  input  wire logic [7:0] d_byte,
  input  wire logic [8:0] sc,
  input  wire logic [8:0] dst_weight,
  input  wire logic [1:0] mode,
  output logic      [7:0] result_byte
);
  import agab_pkg::*;

  logic [15:0] diff;
  logic [24:0] lerp_full;
  logic [16:0] src_full;
  logic [7:0]  s2;
  logic [7:0]  d2;
  logic [15:0] lerp_prod;
  logic [15:0] src_prod;
  logic [16:0] dst_full;
  logic [15:0] over_sum;
  logic [7:0]  lerp_byte;
  logic [7:0]  result_next;

  // Multiply stage: lerp product and scaled source, both kept mod 65536.
  assign diff      = {8'd0, s_byte} - {8'd0, d_byte};
  assign lerp_full = {9'd0, diff} * {16'd0, sc};
  assign src_full  = {9'd0, s_byte} * {8'd0, sc};

  always_ff @(posedge clk) begin
    s2        <= s_byte;
    d2        <= d_byte;
    lerp_prod <= lerp_full[15:0];
    src_prod  <= src_full[15:0];
  end

  // Combine stage: add the scaled destination and pick the mode's result.
  assign dst_full  = {9'd0, d2} * {8'd0, dst_weight};
  assign over_sum  = src_prod + dst_full[15:0];
  assign lerp_byte = d2 + lerp_prod[15:8];

  always_comb begin
    case (mode)
      MODE_LERP:    result_next = lerp_byte;
      MODE_SRCOVER: result_next = over_sum[15:8];
      default:      result_next = s2;
    endcase
  end

  always_ff @(posedge clk) begin
    result_byte <= result_next;
  end

endmodule
`default_nettype wire

// ===== sv/agab_checker.sv =====
`default_nettype none
`include "argb_pixel_global_alpha_blend_macros.svh"
module agab_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);
  // The block takes a word in every cycle.
  `AGAB_ASSERT_NOW(a_never_busy, !busy)

  // Every accepted word gives a result.
  `AGAB_ASSERT_IMPL(a_result_follows, start && !busy, ##3 done)

  // No result without a word accepted before it.
  `AGAB_ASSERT_IMPL(a_no_spurious, done, $past(start && !busy, 3))

endmodule

bind argb_pixel_global_alpha_blend agab_checker u_agab_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
`default_nettype wire

// ===== bench/argb_pixel_global_alpha_blend_tb.sv =====
`timescale 1ns / 100ps

module argb_pixel_global_alpha_blend_tb;
  import agab_pkg::*;

  // Cycles from an accepted word to its result strobe.
  localparam int PIPE_DEPTH = 3;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [31:0]           src_pixel;
  logic [31:0]           dst_pixel;
  logic                  done;
  logic [31:0]           result_pixel;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  argb_pixel_global_alpha_blend dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .src_pixel    (src_pixel),
    .dst_pixel    (dst_pixel),
    .done         (done),
    .result_pixel (result_pixel),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  // Holds a private copy of the two registers and the pixels still owed by the block.
  class blend_scoreboard;
    logic [1:0]  mode;
    logic [7:0]  alpha;
    logic [31:0] expected_pixels[$];
    int          failures;

    function new();
      mode     = BLEND_MODE_RESET;
      alpha    = GLOBAL_ALPHA_RESET;
      failures = 0;
    endfunction

    function void note_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_BLEND_MODE) begin
        mode = data[1:0];
      end else if (idx == REG_GLOBAL_ALPHA) begin
        alpha = data[7:0];
      end
    endfunction

    // Per-byte blend with 16-bit wrapping lanes; the unused mode code falls back to copy.
    function logic [31:0] blend_pixel(logic [31:0] s_px, logic [31:0] d_px);
      int unsigned sc, sa, t, ds, s, d, lane;
      logic [31:0] px;
      sc = 32'(alpha) + 32'd1;
      sa = 32'(s_px[31:24]);
      t  = 16'hFFFF - sa * sc;
      ds = (t + (t >> 8)) >> 8;
      px = s_px;
      for (int k = 0; k < 4; k++) begin
        s = 32'(s_px[8*k +: 8]);
        d = 32'(d_px[8*k +: 8]);
        case (mode)
          MODE_LERP: begin
            lane = (((s - d) & 16'hFFFF) * sc) & 16'hFFFF;
            px[8*k +: 8] = 8'(d + (lane >> 8));
          end
          MODE_SRCOVER: begin
            lane = (s * sc + d * ds) & 16'hFFFF;
            px[8*k +: 8] = 8'(lane >> 8);
          end
          default: px[8*k +: 8] = s_px[8*k +: 8];
        endcase
      end
      return px;
    endfunction

    function void note_input(logic [31:0] s_px, logic [31:0] d_px);
      expected_pixels.push_back(blend_pixel(s_px, d_px));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (expected_pixels.size() == 0) begin
        $error("result_pixel: no word pending, actual %h", got);
        failures++;
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          $error("result_pixel: expected %h, actual %h", want, got);
          failures++;
        end
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  blend_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Every strobed result is checked against the oldest pending word.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(result_pixel);
    end
  end

  // Mix of raw noise, premultiplied pixels, extreme alphas and corner byte values.
  function automatic logic [31:0] random_pixel();
    logic [31:0] px;
    logic [7:0]  a;
    px = $urandom();
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        a = 8'($urandom_range(0, 255));
        px[31:24] = a;
        for (int k = 0; k < 3; k++) px[8*k +: 8] = 8'($urandom_range(0, a));
      end
      2: px[31:24] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: begin
        for (int k = 0; k < 4; k++) begin
          case ($urandom_range(0, 4))
            0: px[8*k +: 8] = 8'h00;
            1: px[8*k +: 8] = 8'hFF;
            2: px[8*k +: 8] = 8'h01;
            3: px[8*k +: 8] = 8'h80;
            default: ;
          endcase
        end
      end
    endcase
    return px;
  endfunction

  // Present one word and hold it until the block takes it.
  task automatic send_word(input logic [31:0] s_px, input logic [31:0] d_px);
    start     <= 1'b1;
    src_pixel <= s_px;
    dst_pixel <= d_px;
    do @(posedge clk); while (busy);
    sb.note_input(s_px, d_px);
  endtask

  // Sender gap with junk on the data ports.
  task automatic idle_cycles(input int n);
    start     <= 1'b0;
    src_pixel <= $urandom();
    dst_pixel <= $urandom();
    repeat (n) @(posedge clk);
  endtask

  // Stop sending and let every pending result come out.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 1) @(posedge clk);
  endtask

  // Leaves wr_en high; the caller lowers it after the last write.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    sb.note_write(idx, data);
  endtask

  // Reconfigure while the block is idle.
  task automatic set_config(input bit do_mode, input logic [CFG_DATA_W-1:0] mode_data,
                            input bit do_alpha, input logic [7:0] alpha_data);
    drain_pipeline();
    if (do_mode) write_reg(REG_BLEND_MODE, mode_data);
    if (do_alpha) write_reg(REG_GLOBAL_ALPHA, alpha_data);
    wr_en <= 1'b0;
  endtask

  task automatic run_phase(input int count, input int idle_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < idle_pct) idle_cycles($urandom_range(1, 8));
      send_word(random_pixel(), random_pixel());
    end
  endtask

  initial begin
    int          idle_pct;
    bit          do_mode;
    bit          do_alpha;
    logic [1:0]  mode_pick;
    logic [7:0]  alpha_pick;

    rst       <= 1'b1;
    start     <= 1'b0;
    src_pixel <= '0;
    dst_pixel <= '0;
    wr_en     <= 1'b0;
    wr_index  <= '0;
    wr_data   <= '0;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: copy with full global alpha.
    send_word(32'h0000_0000, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'h0000_0000);

    // Lerp at both alpha extremes.
    set_config(1'b1, {6'd0, MODE_LERP}, 1'b1, 8'd255);
    send_word(32'hFFFF_FFFF, 32'h0000_0000);
    send_word(32'h0000_0000, 32'hFFFF_FFFF);
    send_word(32'h80FF_0001, 32'h7F00_FF00);
    set_config(1'b0, '0, 1'b1, 8'd0);
    send_word(32'hFFFF_FFFF, 32'h0000_0000);
    send_word(32'h0000_0000, 32'hFFFF_FFFF);

    // Source-over: opaque source, transparent source, sums that wrap, lower global alphas.
    set_config(1'b1, {6'd0, MODE_SRCOVER}, 1'b1, 8'd255);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'h00FF_FFFF, 32'hFFFF_FFFF);
    send_word(32'hFF00_0000, 32'h1234_5678);
    send_word(32'h0000_0000, 32'h0000_0000);
    set_config(1'b0, '0, 1'b1, 8'd0);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'h0000_0000, 32'hFFFF_FFFF);
    set_config(1'b0, '0, 1'b1, 8'd128);
    send_word(32'h80FF_4020, 32'hC0A0_6040);

    // Unused mode code acts as copy; upper data bits of the mode write are junk.
    set_config(1'b1, 8'hFF, 1'b1, 8'd77);
    send_word(32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_word(32'h0000_0000, 32'hFFFF_FFFF);

    // Random phases with random settings; the last stretch runs without gaps.
    for (int p = 0; p < 12; p++) begin
      mode_pick = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: alpha_pick = 8'd0;
        1: alpha_pick = 8'd255;
        default: alpha_pick = 8'($urandom_range(0, 255));
      endcase
      do_mode  = $urandom_range(0, 3) != 0;
      do_alpha = !do_mode || ($urandom_range(0, 3) != 0);
      set_config(do_mode, {6'($urandom_range(0, 63)), mode_pick}, do_alpha, alpha_pick);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (p >= 10) idle_pct = 0;
      run_phase(120, idle_pct);
    end

    drain_pipeline();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule
